/* rtl/core/asfr_pkg.sv */
// shared types, constants and codes for the adc serial frame reader
package asfr_pkg;

    // converter geometry
    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int CHAN_W      = 3;
    localparam int BIT_IDX_W   = $clog2(SAMPLE_BITS);
    localparam int MV_W        = 15;
    localparam int STATUS_W    = 3;

    // configuration register widths
    localparam int CONVST_W    = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int HALF_W      = 8;
    localparam int RANGE_W     = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [CONVST_W-1:0]  CONVST_RST  = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2000;
    localparam logic [HALF_W-1:0]    HALF_RST    = 8'd2;
    localparam logic [RANGE_W-1:0]   RANGE_RST   = 14'd5000;

    // millivolt scaling: (mag * range + half lsb) >> 15
    localparam int MV_SHIFT = 15;
    localparam int PROD_W   = SAMPLE_BITS + RANGE_W;
    localparam logic [PROD_W-1:0] MV_ROUND = PROD_W'(1 << (MV_SHIFT - 1));

    // stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONVST_LOW  = 2'd0,
        CFG_BUSY_TIMEOUT = 2'd1,
        CFG_SCLK_HALF   = 2'd2,
        CFG_RANGE_MV    = 2'd3
    } cfg_idx_t;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY_TO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FIRST_TO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd4;

    // timing configuration seen by the controller
    typedef struct packed {
        logic [CONVST_W-1:0]  convst_low_ticks;
        logic [TIMEOUT_W-1:0] busy_timeout_ticks;
        logic [HALF_W-1:0]    sclk_half_ticks;
    } ctrl_cfg_t;

    // controller result before millivolt scaling
    typedef struct packed {
        logic                    convst_n;
        logic                    cs_n;
        logic                    sclk;
        logic                    ready_res;
        logic                    sample_valid;
        logic [CHAN_W-1:0]       channel;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    neg;
        logic [SAMPLE_BITS-1:0]  mag;
        logic                    last_of_frame;
        logic [STATUS_W-1:0]     status;
    } ctrl_res_t;

endpackage

/* rtl/core/asfr_ctrl.sv */
// tick controller: conversion, busy waits, frame shifter, first result register
module asfr_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  asfr_pkg::ctrl_cfg_t       cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic                      busy_req,
    input  logic                      first_data,
    input  logic                      serial_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output asfr_pkg::ctrl_res_t       out_res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CONVST  = 4'd1,
        PH_BUSY_HI = 4'd2,
        PH_BUSY_LO = 4'd3,
        PH_FIRST   = 4'd4,
        PH_SHIFT   = 4'd5
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [asfr_pkg::TIMEOUT_W-1:0]      wait_reg, wait_next;
    logic [asfr_pkg::CONVST_W-1:0]       pulse_reg, pulse_next;
    logic [asfr_pkg::CHAN_W-1:0]         word_reg, word_next;
    logic [asfr_pkg::BIT_IDX_W-1:0]      bit_reg, bit_next;
    logic [asfr_pkg::SAMPLE_BITS-1:0]    shift_reg, shift_next;
    logic [asfr_pkg::HALF_W-1:0]         div_reg, div_next;
    logic                                lvl_reg, lvl_next;
    logic                                valid_reg;
    asfr_pkg::ctrl_res_t                 res_reg, res_next;

    logic                                accept;
    logic [asfr_pkg::TIMEOUT_W:0]        wait_inc;
    logic                                miss_hit;
    logic [asfr_pkg::HALF_W-1:0]         div_inc;
    logic                                vld;
    logic [asfr_pkg::CHAN_W-1:0]         chan;
    logic [asfr_pkg::SAMPLE_BITS-1:0]    samp;
    logic                                last;
    logic [asfr_pkg::STATUS_W-1:0]       status;

    // handshake: the result register frees when downstream takes it
    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // shared wait-counter step for the busy and first-data waits (the convst pulse has its own counter)
    assign wait_inc = {1'b0, wait_reg} + 1'b1;
    assign miss_hit = wait_inc >= {1'b0, cfg.busy_timeout_ticks};
    assign div_inc  = div_reg + 1'b1;

    // next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        pulse_next = pulse_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        lvl_next   = lvl_reg;
        vld        = 1'b0;
        chan       = '0;
        samp       = '0;
        last       = 1'b0;
        status     = asfr_pkg::ST_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                if (operation == asfr_pkg::OP_START)
                begin
                    phase_next = PH_CONVST;
                    pulse_next = asfr_pkg::CONVST_W'(1);
                end
                else if (operation == asfr_pkg::OP_READ)
                begin
                    if (busy_req)
                    begin
                        status = asfr_pkg::ST_NOT_READY;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                        wait_next  = '0;
                    end
                end
            end
            PH_CONVST:
            begin
                if (pulse_reg >= cfg.convst_low_ticks)
                begin
                    pulse_next = '0;
                    phase_next = PH_BUSY_HI;
                    wait_next  = '0;
                end
                else
                begin
                    pulse_next = pulse_reg + 1'b1;
                end
            end
            PH_BUSY_HI:
            begin
                if (busy_req)
                begin
                    phase_next = PH_BUSY_LO;
                    wait_next  = '0;
                end
                else if (miss_hit)
                begin
                    wait_next  = '0;
                    phase_next = PH_IDLE;
                    status     = asfr_pkg::ST_BUSY_TO;
                end
                else
                begin
                    wait_next = wait_inc[asfr_pkg::TIMEOUT_W-1:0];
                end
            end
            PH_BUSY_LO:
            begin
                if (!busy_req)
                begin
                    phase_next = PH_FIRST;
                    wait_next  = '0;
                end
                else if (miss_hit)
                begin
                    wait_next  = '0;
                    phase_next = PH_IDLE;
                    status     = asfr_pkg::ST_BUSY_TO;
                end
                else
                begin
                    wait_next = wait_inc[asfr_pkg::TIMEOUT_W-1:0];
                end
            end
            PH_FIRST:
            begin
                if (first_data)
                begin
                    phase_next = PH_SHIFT;
                    wait_next  = '0;
                    word_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                    div_next   = '0;
                    lvl_next   = 1'b1;
                end
                else if (miss_hit)
                begin
                    wait_next  = '0;
                    phase_next = PH_IDLE;
                    status     = asfr_pkg::ST_FIRST_TO;
                end
                else
                begin
                    wait_next = wait_inc[asfr_pkg::TIMEOUT_W-1:0];
                end
            end
            PH_SHIFT:
            begin
                // any count reaches a zero half period, so it acts as one; a count that wraps to zero also toggles
                if (div_inc >= cfg.sclk_half_ticks || div_inc == '0)
                begin
                    div_next = '0;
                    lvl_next = !lvl_reg;
                    // capture on the rising sclk edge
                    if (!lvl_reg)
                    begin
                        shift_next = {shift_reg[asfr_pkg::SAMPLE_BITS-2:0], serial_in};
                        bit_next   = bit_reg + 1'b1;
                        if (bit_reg == asfr_pkg::BIT_IDX_W'(asfr_pkg::SAMPLE_BITS - 1))
                        begin
                            bit_next = '0;
                            vld      = 1'b1;
                            chan     = word_reg;
                            samp     = shift_next;
                            if (word_reg == asfr_pkg::CHAN_W'(asfr_pkg::CHANNELS - 1))
                            begin
                                last       = 1'b1;
                                status     = asfr_pkg::ST_DONE;
                                phase_next = PH_IDLE;
                                word_next  = '0;
                            end
                            else
                            begin
                                word_next = word_reg + 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    div_next = div_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // sclk parks high outside a frame
        if (phase_next != PH_SHIFT)
        begin
            lvl_next = 1'b1;
            div_next = '0;
        end
    end

    // pin levels and word fields for the result register
    always_comb
    begin
        res_next.convst_n      = (phase_next != PH_CONVST);
        res_next.cs_n          = !(phase_next == PH_FIRST || phase_next == PH_SHIFT);
        res_next.sclk          = lvl_next;
        res_next.ready_res     = (phase_next == PH_IDLE);
        res_next.sample_valid  = vld;
        res_next.channel       = chan;
        res_next.sample        = samp;
        res_next.neg           = samp[asfr_pkg::SAMPLE_BITS-1];
        res_next.mag           = samp[asfr_pkg::SAMPLE_BITS-1] ? (~samp + 1'b1) : samp;
        res_next.last_of_frame = last;
        res_next.status        = status;
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            pulse_reg <= '0;
            word_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            div_reg   <= '0;
            lvl_reg   <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
                pulse_reg <= pulse_next;
                word_reg  <= word_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                div_reg   <= div_next;
                lvl_reg   <= lvl_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/core/asfr_scale.sv */
// millivolt scaling stage and output register
module asfr_scale
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [asfr_pkg::RANGE_W-1:0]        range_mv,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  asfr_pkg::ctrl_res_t                 in_res,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [asfr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic [asfr_pkg::STATUS_W-1:0]       m_tuser
);

    logic                                valid_reg;
    logic [asfr_pkg::M_DATA_W-1:0]       data_reg, data_next;
    logic                                last_reg;
    logic [asfr_pkg::STATUS_W-1:0]       user_reg;
    logic [asfr_pkg::PROD_W-1:0]         prod;
    logic [asfr_pkg::MV_W-1:0]           mv_mag;
    logic [asfr_pkg::MV_W-1:0]           mv;
    logic                                load;

    assign in_ready = !valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    // round(|code| * range / 32768), then restore the sign
    assign prod   = asfr_pkg::PROD_W'(in_res.mag) * asfr_pkg::PROD_W'(range_mv)
                    + asfr_pkg::MV_ROUND;
    assign mv_mag = prod[asfr_pkg::MV_SHIFT +: asfr_pkg::MV_W];
    assign mv     = in_res.neg ? (~mv_mag + 1'b1) : mv_mag;

    // pack result fields, lowest first
    assign data_next = {1'b0, mv, in_res.sample, in_res.channel, in_res.sample_valid,
                        in_res.ready_res, in_res.sclk, in_res.cs_n, in_res.convst_n};

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            last_reg <= in_res.last_of_frame;
            user_reg <= in_res.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

/* rtl/core/adc_serial_frame_reader.sv */
// top level: serial frame reader for an 8-channel simultaneous-sampling adc
// path: an accepted tick request is registered in the controller result register, then in the scaling output register
// throughput: one tick request per cycle while the result side does not stall; every request yields exactly one result
// the whole tick update is computed and registered in the controller, scaling follows in the scaling stage
// reset: asynchronous, active low; controller idle, sclk high, registers at defaults
// configuration writes are taken every cycle (cfg_ready stays high)
module adc_serial_frame_reader
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // tick requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // operation[1:0], busy_req[2], first_data[3], serial_in[4], zero[7:5]
    input  logic [asfr_pkg::S_DATA_W-1:0]        s_tdata,
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // convst_n[0], cs_n[1], sclk[2], ready_res[3], sample_valid[4], channel[7:5],
    // sample[23:8], millivolts[38:24], zero[39]
    output logic [asfr_pkg::M_DATA_W-1:0]        m_tdata,
    // last_of_frame
    output logic                                 m_tlast,
    // status[2:0]
    output logic [asfr_pkg::STATUS_W-1:0]        m_tuser
);

    logic [asfr_pkg::CONVST_W-1:0]   convst_low_reg;
    logic [asfr_pkg::TIMEOUT_W-1:0]  timeout_reg;
    logic [asfr_pkg::HALF_W-1:0]     half_reg;
    logic [asfr_pkg::RANGE_W-1:0]    range_reg;
    asfr_pkg::ctrl_cfg_t             ctrl_cfg;
    asfr_pkg::ctrl_res_t             ctrl_res;
    logic                            ctrl_valid;
    logic                            scale_ready;
    asfr_pkg::cfg_idx_t              cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = asfr_pkg::cfg_idx_t'(cfg_index);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            convst_low_reg <= asfr_pkg::CONVST_RST;
            timeout_reg    <= asfr_pkg::TIMEOUT_RST;
            half_reg       <= asfr_pkg::HALF_RST;
            range_reg      <= asfr_pkg::RANGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_sel)
                asfr_pkg::CFG_CONVST_LOW:   convst_low_reg <= cfg_data[asfr_pkg::CONVST_W-1:0];
                asfr_pkg::CFG_BUSY_TIMEOUT: timeout_reg    <= cfg_data[asfr_pkg::TIMEOUT_W-1:0];
                asfr_pkg::CFG_SCLK_HALF:    half_reg       <= cfg_data[asfr_pkg::HALF_W-1:0];
                asfr_pkg::CFG_RANGE_MV:     range_reg      <= cfg_data[asfr_pkg::RANGE_W-1:0];
                default:                    range_reg      <= range_reg;
            endcase
        end
    end

    assign ctrl_cfg.convst_low_ticks   = convst_low_reg;
    assign ctrl_cfg.busy_timeout_ticks = timeout_reg;
    assign ctrl_cfg.sclk_half_ticks    = half_reg;

    // tick controller
    asfr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (ctrl_cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .operation  (s_tdata[1:0]),
        .busy_req   (s_tdata[2]),
        .first_data (s_tdata[3]),
        .serial_in  (s_tdata[4]),
        .out_valid  (ctrl_valid),
        .out_ready  (scale_ready),
        .out_res    (ctrl_res)
    );

    // millivolt scaling and output register
    asfr_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .range_mv (range_reg),
        .in_valid (ctrl_valid),
        .in_ready (scale_ready),
        .in_res   (ctrl_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/asfr_checker.sv */
// port-level checker for the adc serial frame reader, with its bind
module asfr_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [asfr_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             m_tlast,
    input  logic [asfr_pkg::STATUS_W-1:0]    m_tuser
);

    // a stalled result stays valid and holds its data and status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // frame end carries a word, done status, released chip select and idle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == asfr_pkg::ST_DONE && m_tdata[4]
                                && m_tdata[1] && m_tdata[3])
        else $error("frame end without word or done status");

    // no word means zero word fields and no frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> m_tdata[38:5] == '0 && !m_tlast)
        else $error("word fields set without a word");

    // any status event leaves the controller idle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != asfr_pkg::ST_NONE |-> m_tdata[3] && m_tdata[0])
        else $error("status reported while busy");

    // conversion pulse never overlaps chip select
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[1] && !m_tdata[3] && m_tdata[2])
        else $error("convst low during a frame");

endmodule

bind adc_serial_frame_reader asfr_checker u_asfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* dv/adc_serial_frame_reader_test.sv */
// testbench for the adc serial frame reader: per-tick prediction checked against every result
module adc_serial_frame_reader_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asfr_pkg::*;

    // unused operation code, treated as a plain tick
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles to let pass after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 4;
    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // random ticks per random phase
    localparam int PHASE_TICKS = 100;
    // number of random phases
    localparam int PHASES = 3;

    // codes at the edges of the range and of the rounding
    localparam logic [SAMPLE_BITS-1:0] EDGE_CODES [CHANNELS] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000, 16'h0001, 16'h8001
    };

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CONVST,
        PH_BUSY_HI,
        PH_BUSY_LO,
        PH_FIRST,
        PH_SHIFT
    } phase_t;

    // line levels and word delivered by one tick
    typedef struct packed {
        logic                   convst_n;
        logic                   cs_n;
        logic                   sclk;
        logic                   ready_res;
        logic                   sample_valid;
        logic [CHAN_W-1:0]      channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic [MV_W-1:0]        millivolts;
        logic                   last_of_frame;
        logic [STATUS_W-1:0]    status;
    } tick_result_t;

    // tracks the controller tick by tick and holds the line levels still to come
    class frame_tracker;
        logic [CONVST_W-1:0]    convst_low;
        logic [TIMEOUT_W-1:0]   timeout;
        logic [HALF_W-1:0]      half_period;
        logic [RANGE_W-1:0]     range;

        phase_t                 phase;
        logic [TIMEOUT_W-1:0]   wait_cnt;
        logic [CONVST_W-1:0]    pulse_cnt;
        int unsigned            word_idx;
        int unsigned            bit_idx;
        logic [SAMPLE_BITS-1:0] shift_reg;
        logic [HALF_W-1:0]      divider;
        logic                   sclk_level;

        tick_result_t           expected_q[$];
        int                     errors;

        function new();
            convst_low  = CONVST_RST;
            timeout     = TIMEOUT_RST;
            half_period = HALF_RST;
            range       = RANGE_RST;
            phase       = PH_IDLE;
            wait_cnt    = '0;
            pulse_cnt   = '0;
            word_idx    = 0;
            bit_idx     = 0;
            shift_reg   = '0;
            divider     = '0;
            sclk_level  = 1'b1;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (cfg_idx_t'(idx))
                CFG_CONVST_LOW:   convst_low  = value[CONVST_W-1:0];
                CFG_BUSY_TIMEOUT: timeout     = value[TIMEOUT_W-1:0];
                CFG_SCLK_HALF:    half_period = value[HALF_W-1:0];
                CFG_RANGE_MV:     range       = value[RANGE_W-1:0];
                default:          ;
            endcase
        endfunction

        // one missed sample in a wait, true on the tick the wait runs out
        function bit count_miss();
            logic [TIMEOUT_W:0] nxt;
            nxt = {1'b0, wait_cnt} + (TIMEOUT_W + 1)'(1);
            if (nxt >= {1'b0, timeout})
            begin
                wait_cnt = '0;
                return 1'b1;
            end
            wait_cnt = nxt[TIMEOUT_W-1:0];
            return 1'b0;
        endfunction

        // symmetric rounding of |code| * range / 32768, sign put back
        function logic [MV_W-1:0] scale_mv(logic [SAMPLE_BITS-1:0] code);
            int unsigned mag;
            int unsigned mv;
            mag = code[SAMPLE_BITS-1] ? (32'h10000 - 32'(code)) : 32'(code);
            mv  = (mag * 32'(range) + 32'd16384) / 32'd32768;
            return code[SAMPLE_BITS-1] ? MV_W'(32'h8000 - mv) : MV_W'(mv);
        endfunction

        function void take_tick(logic [S_DATA_W-1:0] d);
            logic [1:0]   op;
            logic         busy;
            logic         first;
            logic         sdi;
            tick_result_t r;
            op    = d[1:0];
            busy  = d[2];
            first = d[3];
            sdi   = d[4];
            r     = '0;
            case (phase)
                PH_IDLE:
                begin
                    if (op == OP_START)
                    begin
                        phase     = PH_CONVST;
                        pulse_cnt = CONVST_W'(1);
                    end
                    else if (op == OP_READ)
                    begin
                        if (busy)
                        begin
                            r.status = ST_NOT_READY;
                        end
                        else
                        begin
                            phase    = PH_FIRST;
                            wait_cnt = '0;
                        end
                    end
                end
                PH_CONVST:
                begin
                    if (pulse_cnt >= convst_low)
                    begin
                        pulse_cnt = '0;
                        phase     = PH_BUSY_HI;
                        wait_cnt  = '0;
                    end
                    else
                    begin
                        pulse_cnt = pulse_cnt + CONVST_W'(1);
                    end
                end
                PH_BUSY_HI:
                begin
                    if (busy)
                    begin
                        phase    = PH_BUSY_LO;
                        wait_cnt = '0;
                    end
                    else if (count_miss())
                    begin
                        phase    = PH_IDLE;
                        r.status = ST_BUSY_TO;
                    end
                end
                PH_BUSY_LO:
                begin
                    if (!busy)
                    begin
                        phase    = PH_FIRST;
                        wait_cnt = '0;
                    end
                    else if (count_miss())
                    begin
                        phase    = PH_IDLE;
                        r.status = ST_BUSY_TO;
                    end
                end
                PH_FIRST:
                begin
                    if (first)
                    begin
                        phase      = PH_SHIFT;
                        wait_cnt   = '0;
                        word_idx   = 0;
                        bit_idx    = 0;
                        shift_reg  = '0;
                        divider    = '0;
                        sclk_level = 1'b1;
                    end
                    else if (count_miss())
                    begin
                        phase    = PH_IDLE;
                        r.status = ST_FIRST_TO;
                    end
                end
                PH_SHIFT:
                begin
                    // sclk toggles every half period, data taken on the rising edge
                    divider = divider + HALF_W'(1);
                    if (divider >= half_period || divider == '0)
                    begin
                        divider    = '0;
                        sclk_level = ~sclk_level;
                        if (sclk_level)
                        begin
                            shift_reg = {shift_reg[SAMPLE_BITS-2:0], sdi};
                            bit_idx++;
                            if (bit_idx >= SAMPLE_BITS)
                            begin
                                bit_idx        = 0;
                                r.sample_valid = 1'b1;
                                r.channel      = word_idx[CHAN_W-1:0];
                                r.sample       = shift_reg;
                                r.millivolts   = scale_mv(shift_reg);
                                if (word_idx + 1 >= CHANNELS)
                                begin
                                    r.last_of_frame = 1'b1;
                                    r.status        = ST_DONE;
                                    phase           = PH_IDLE;
                                    word_idx        = 0;
                                end
                                else
                                begin
                                    word_idx++;
                                end
                            end
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase

            // line levels after the tick
            r.convst_n = (phase != PH_CONVST);
            r.cs_n     = !(phase == PH_FIRST || phase == PH_SHIFT);
            if (phase != PH_SHIFT)
            begin
                sclk_level = 1'b1;
                divider    = '0;
            end
            r.sclk      = sclk_level;
            r.ready_res = (phase == PH_IDLE);
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] expv, logic [31:0] actv);
            if (expv != actv)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
            end
        endfunction

        function void match_result(logic [M_DATA_W-1:0] d, logic last,
                                   logic [STATUS_W-1:0] user);
            tick_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result %h with nothing pending", $time, d);
                return;
            end
            exp_r = expected_q.pop_front();
            field_check("convst_n", 32'(exp_r.convst_n), 32'(d[0]));
            field_check("cs_n", 32'(exp_r.cs_n), 32'(d[1]));
            field_check("sclk", 32'(exp_r.sclk), 32'(d[2]));
            field_check("ready_res", 32'(exp_r.ready_res), 32'(d[3]));
            field_check("sample_valid", 32'(exp_r.sample_valid), 32'(d[4]));
            field_check("channel", 32'(exp_r.channel), 32'(d[7:5]));
            field_check("sample", 32'(exp_r.sample), 32'(d[23:8]));
            field_check("millivolts", 32'(exp_r.millivolts), 32'(d[38:24]));
            field_check("last_of_frame", 32'(exp_r.last_of_frame), 32'(last));
            field_check("status", 32'(exp_r.status), 32'(user));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report_leftovers();
            if (expected_q.size() != 0)
            begin
                errors++;
                $display("%0t: %0d results never arrived", $time, expected_q.size());
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;

    frame_tracker          sb;
    bit                    idle_on = 1'b1;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;
    int                    ticks_sent = 0;
    logic [SAMPLE_BITS-1:0] frame_words [CHANNELS];

    adc_serial_frame_reader u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        forever #4ns clk = ~clk;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [1:0] rand_op();
        return 2'($urandom_range(0, 3));
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // words of the next frame, edge codes or random codes
    function automatic void fill_words(bit edges_only);
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (edges_only)
                frame_words[CHAN_W'(i)] = EDGE_CODES[CHAN_W'(i)];
            else if ($urandom_range(0, 3) == 0)
                frame_words[CHAN_W'(i)] = EDGE_CODES[CHAN_W'($urandom_range(0, CHANNELS - 1))];
            else
                frame_words[CHAN_W'(i)] = 16'($urandom_range(0, 65535));
        end
    endfunction

    // result side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitors: register writes, accepted ticks, results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.take_tick(s_tdata);
            if (m_tvalid && m_tready)
                sb.match_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[adc_serial_frame_reader] ERROR");
                $finish;
            end
        end
    end

    // one tick request, valid dropped first for a gap if one is picked, else kept up
    task automatic send_tick(input logic [1:0] op, input logic busy, input logic first,
                             input logic sdi);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sdi, first, busy, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_sent++;
    endtask

    // hold off until every pending result is in, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input int convst, input int tmo, input int half, input int rng);
        write_cfg(CFG_CONVST_LOW, CFG_DATA_W'(convst));
        write_cfg(CFG_BUSY_TIMEOUT, CFG_DATA_W'(tmo));
        write_cfg(CFG_SCLK_HALF, CFG_DATA_W'(half));
        write_cfg(CFG_RANGE_MV, CFG_DATA_W'(rng));
    endtask

    // ticks the idle controller ignores or refuses
    task automatic idle_noise(input int n);
        int r;
        repeat (n)
        begin
            r = int'($urandom_range(0, 2));
            if (r == 0)
                send_tick(OP_TICK, rand_bit(), rand_bit(), rand_bit());
            else if (r == 1)
                send_tick(OP_UNUSED, rand_bit(), rand_bit(), rand_bit());
            else
                send_tick(OP_READ, 1'b1, rand_bit(), rand_bit());
        end
    endtask

    // one acquisition; a wait of at least the timeout ends it with that timeout
    task automatic run_acquisition(input logic [1:0] op, input int hi_wait, input int lo_wait,
                                   input int first_wait);
        int limit;
        int half;
        int m;
        logic sdi;
        limit = (sb.timeout == '0) ? 1 : int'(sb.timeout);
        half  = (sb.half_period == '0) ? 1 : int'(sb.half_period);
        if (op == OP_START)
        begin
            send_tick(OP_START, rand_bit(), rand_bit(), rand_bit());
            // convst pulse, pins ignored
            repeat ((sb.convst_low == '0) ? 1 : int'(sb.convst_low))
                send_tick(rand_op(), rand_bit(), rand_bit(), rand_bit());
            // busy rises
            repeat ((hi_wait < limit) ? hi_wait : limit)
                send_tick(rand_op(), 1'b0, rand_bit(), rand_bit());
            if (hi_wait >= limit)
                return;
            send_tick(rand_op(), 1'b1, rand_bit(), rand_bit());
            // busy falls
            repeat ((lo_wait < limit) ? lo_wait : limit)
                send_tick(rand_op(), 1'b1, rand_bit(), rand_bit());
            if (lo_wait >= limit)
                return;
            send_tick(rand_op(), 1'b0, rand_bit(), rand_bit());
        end
        else
        begin
            send_tick(OP_READ, 1'b0, rand_bit(), rand_bit());
        end
        // first-data flag
        repeat ((first_wait < limit) ? first_wait : limit)
            send_tick(rand_op(), rand_bit(), 1'b0, rand_bit());
        if (first_wait >= limit)
            return;
        send_tick(rand_op(), rand_bit(), 1'b1, rand_bit());
        // shift phase, word bits land on the rising sclk ticks
        for (int j = 1; j <= CHANNELS * SAMPLE_BITS * 2 * half; j++)
        begin
            if (j % (2 * half) == 0)
            begin
                m   = j / (2 * half) - 1;
                sdi = frame_words[CHAN_W'(m / SAMPLE_BITS)]
                                 [BIT_IDX_W'(SAMPLE_BITS - 1 - (m % SAMPLE_BITS))];
            end
            else
            begin
                sdi = rand_bit();
            end
            send_tick(rand_op(), rand_bit(), rand_bit(), sdi);
        end
    endtask

    // waits mostly short, sometimes right at the timeout edge
    function automatic int short_wait(input int limit);
        if ($urandom_range(0, 4) == 0)
            return limit - 1;
        return int'($urandom_range(0, (limit - 1 < 6) ? limit - 1 : 6));
    endfunction

    // mostly complete acquisitions, the rest broken ones and noise
    task automatic random_sequence();
        int limit;
        int r;
        limit = (sb.timeout == '0) ? 1 : int'(sb.timeout);
        r = int'($urandom_range(0, 99));
        fill_words(1'b0);
        if (r < 40)
            run_acquisition(OP_START, short_wait(limit), short_wait(limit), short_wait(limit));
        else if (r < 70)
            run_acquisition(OP_READ, 0, 0, short_wait(limit));
        else if (r < 76)
            run_acquisition(OP_START, limit, 0, 0);
        else if (r < 82)
            run_acquisition(OP_START, short_wait(limit), limit, 0);
        else if (r < 90)
            run_acquisition($urandom_range(0, 1) ? OP_START : OP_READ, short_wait(limit),
                            short_wait(limit), limit);
        else
            idle_noise(int'($urandom_range(1, 6)));
    endtask

    initial
    begin
        int start_ticks;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: full frame, refused read, unused code
        fill_words(1'b1);
        run_acquisition(OP_START, 0, 2, 1);
        send_tick(OP_READ, 1'b1, 1'b0, 1'b0);
        send_tick(OP_UNUSED, 1'b0, 1'b1, 1'b1);
        drain_results();

        // zero registers act as one, smallest range
        set_timing(0, 0, 0, 1);
        fill_words(1'b1);
        run_acquisition(OP_START, 0, 0, 0);
        run_acquisition(OP_START, 1, 0, 0);
        run_acquisition(OP_START, 0, 1, 0);
        run_acquisition(OP_READ, 0, 0, 1);
        idle_noise(4);
        drain_results();

        // largest timeout and conversion pulse, range 10000, no idling
        idle_on = 1'b0;
        set_timing(1023, 65535, 1, 10000);
        fill_words(1'b1);
        run_acquisition(OP_READ, 0, 0, 2);
        drain_results();

        // random phases with short timing
        idle_on = 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            set_timing(int'($urandom_range(1, 12)),
                       (p == 1) ? 1 : int'($urandom_range(1, 24)), 1,
                       (p == 0) ? 10000 : ((p == 1) ? 1 : int'($urandom_range(1, 10000))));
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < PHASE_TICKS)
            begin
                if ($urandom_range(0, 4) == 0)
                    idle_on = !idle_on;
                if ($urandom_range(0, 7) == 0)
                    drain_results();
                random_sequence();
            end
            drain_results();
            idle_on = 1'b1;
        end

        sb.report_leftovers();
        if (sb.errors == 0)
            $display("[adc_serial_frame_reader] OK");
        else
            $display("[adc_serial_frame_reader] ERROR");
        $finish;
    end

endmodule

/* adc_serial_frame_reader.f */
rtl/core/asfr_pkg.sv
rtl/core/asfr_ctrl.sv
rtl/core/asfr_scale.sv
rtl/core/adc_serial_frame_reader.sv
rtl/core/asfr_checker.sv
dv/adc_serial_frame_reader_test.sv
